// ===== sv/lmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg: shared types and constants of the LED matrix scan driver
// Command layout between the front end, the queue and the back end, the
// opcodes seen on the request stream and the gamma ROM builder.
// ----------------------------------------------------------------------------
package lmd_pkg;

   // Panel and chain geometry
   localparam int CHAIN_LEN   = 256;
   localparam int ADDR_W      = $clog2(CHAIN_LEN);
   localparam int LEVEL_W     = 8;
   localparam int PHASE_OUT_W = 6;
   localparam int GREY_W      = 16;
   localparam int COORD_W     = 16;

   // Request opcodes (code 3 is unused and ignored)
   localparam logic [1:0] OP_DRAW = 2'd0;
   localparam logic [1:0] OP_SHOW = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Clamp limit of the grey level before the gamma lookup
   localparam logic [LEVEL_W-1:0] GREY_MAX = 8'hFF;

   // Gamma curve exponent 2.7 as the ratio 27 / 10, and the width of the
   // exact integer powers used to build the curve
   localparam int GAMMA_NUM = 27;
   localparam int GAMMA_DEN = 10;
   localparam int GAMMA_W   = 300;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_DRAW,
      CMD_SHOW,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ADDR_W-1:0]   addr;
      logic [LEVEL_W-1:0]  level;
   } cmd_type;

   typedef enum logic {
      BK_RUN,
      BK_COPY
   } back_state_type;

   typedef struct packed {
      logic copy_busy;
      logic blank;
      logic tick_issue;
   } back_status_type;

   typedef logic [CHAIN_LEN-1:0][LEVEL_W-1:0] gamma_rom_type;

   // Build the gamma ROM: entry 0 is dark, entry i is
   // floor(1 + (2^bits - 1) * (i/256)^2.7), taken exactly as the largest k
   // with k^10 * 256^27 <= (2^bits - 1)^10 * i^27, plus one
   function automatic gamma_rom_type build_gamma(int bits);
      gamma_rom_type      rom;
      logic [GAMMA_W-1:0] full_pow;
      logic [GAMMA_W-1:0] rhs;
      logic [GAMMA_W-1:0] lhs;
      int                 full;
      int                 k;
      bit                 grow;
      rom      = '0;
      full     = (1 << bits) - 1;
      k        = 0;
      full_pow = GAMMA_W'(1);
      for (int j = 0; j < GAMMA_DEN; j++) begin
         full_pow = full_pow * GAMMA_W'(full);
      end
      for (int i = 1; i < CHAIN_LEN; i++) begin
         rhs = full_pow;
         for (int j = 0; j < GAMMA_NUM; j++) begin
            rhs = rhs * GAMMA_W'(i);
         end
         grow = 1'b1;
         while (grow && k < full) begin
            lhs = GAMMA_W'(1);
            for (int j = 0; j < GAMMA_DEN; j++) begin
               lhs = lhs * GAMMA_W'(k + 1);
            end
            lhs = lhs << (ADDR_W * GAMMA_NUM);
            if (lhs <= rhs) begin
               k++;
            end else begin
               grow = 1'b0;
            end
         end
         rom[i] = LEVEL_W'(k + 1);
      end
      return rom;
   endfunction

endpackage

// ===== sv/lmd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held while the
// read enable is low.
// ----------------------------------------------------------------------------
module lmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_front: request decoder
// Classifies request items, drops off-panel draws and unused opcodes, maps
// the pixel to its shift-chain address and looks up the gamma level.
// ----------------------------------------------------------------------------
module lmd_front import lmd_pkg::*; #(
   parameter int PWM_BITS = 6
) (
   input  logic [1:0]             opcode,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] y_coord,
   input  logic [GREY_W-1:0]      grey_level,
   output cmd_type                cmd,
   output logic                   keep
);

   localparam gamma_rom_type GAMMA_ROM = build_gamma(PWM_BITS);

   logic               on_panel;
   logic [3:0]         col;
   logic [3:0]         row;
   logic [2:0]         c;
   logic [5:0]         offset;
   logic [LEVEL_W-1:0] grey_idx;
   logic [LEVEL_W-1:0] gamma_level;

   // Position check: both coordinates in 0..15
   assign on_panel = (x_coord[COORD_W-1:4] == '0) && (y_coord[COORD_W-1:4] == '0);

   // Mirror the column
   assign col = ~x_coord[3:0];
   assign row = y_coord[3:0];
   assign c   = col[2:0];

   // Serpentine offset inside one 64-LED board
   always_comb begin
      case ({row[1:0], col[3]})
         3'd0:    offset = {3'b000, c};
         3'd1:    offset = 6'd16 + {3'b000, c};
         3'd2:    offset = 6'd15 - {3'b000, c};
         3'd3:    offset = 6'd31 - {3'b000, c};
         3'd4:    offset = 6'd48 + {3'b000, c};
         3'd5:    offset = 6'd32 + {3'b000, c};
         3'd6:    offset = 6'd63 - {3'b000, c};
         default: offset = 6'd47 - {3'b000, c};
      endcase
   end

   // Clamp the grey level and look up the gamma curve
   assign grey_idx    = (grey_level[GREY_W-1:LEVEL_W] != '0) ? GREY_MAX
                                                             : grey_level[LEVEL_W-1:0];
   assign gamma_level = GAMMA_ROM[grey_idx];

   // Classify the item
   always_comb begin
      cmd.addr  = {row[3:2], offset};
      cmd.level = gamma_level;
      cmd.kind  = CMD_TICK;
      keep      = 1'b0;
      case (opcode)
         OP_DRAW: begin
            cmd.kind = CMD_DRAW;
            keep     = on_panel;
         end
         OP_SHOW: begin
            cmd.kind = CMD_SHOW;
            keep     = 1'b1;
         end
         OP_TICK: begin
            cmd.kind = CMD_TICK;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/lmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_queue: command queue
// Short FIFO between the decoder and the back end.
// ----------------------------------------------------------------------------
module lmd_queue import lmd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

endmodule

// ===== sv/lmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_back: command executor
// Writes draws into the front buffer, copies front to back on a show and
// scans the back buffer into the result register on each shift tick once lit.
// ----------------------------------------------------------------------------
module lmd_back import lmd_pkg::*; #(
   parameter int PWM_BITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  cmd_type                head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_bit,
   output logic                   rsp_latch,
   output logic [PHASE_OUT_W-1:0] rsp_phase,
   output back_status_type        status
);

   back_state_type      state_ff, state_in;
   logic [ADDR_W:0]     cnt_ff, cnt_in;
   logic                blank_ff, blank_in;
   logic [PWM_BITS-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [CHAIN_LEN-1:0] fvalid_ff;
   logic                fv_rd_ff;
   logic                pend_ff, pend_in;
   logic [PWM_BITS-1:0] pend_phase_ff;
   logic                pend_latch_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_bit_ff;
   logic                rsp_latch_ff;
   logic [PHASE_OUT_W-1:0] rsp_phase_ff;

   logic                fwr_en;
   logic                frd_en;
   logic [ADDR_W-1:0]   frd_addr;
   logic [LEVEL_W-1:0]  frd_data;
   logic                bwr_en;
   logic [ADDR_W-1:0]   bwr_addr;
   logic [LEVEL_W-1:0]  bwr_data;
   logic                brd_en;
   logic [LEVEL_W-1:0]  brd_data;
   logic                tick_issue;
   logic                slot_move;
   logic                issue_ok;
   logic [PWM_BITS-1:0] phase_next;

   lmd_ram #(.WIDTH(LEVEL_W), .DEPTH(CHAIN_LEN)) u_front_ram (
      .clock   (clock),
      .wr_en   (fwr_en),
      .wr_addr (head_cmd.addr),
      .wr_data (head_cmd.level),
      .rd_en   (frd_en),
      .rd_addr (frd_addr),
      .rd_data (frd_data)
   );

   lmd_ram #(.WIDTH(LEVEL_W), .DEPTH(CHAIN_LEN)) u_back_ram (
      .clock   (clock),
      .wr_en   (bwr_en),
      .wr_addr (bwr_addr),
      .wr_data (bwr_data),
      .rd_en   (brd_en),
      .rd_addr (pos_ff),
      .rd_data (brd_data)
   );

   // Pending tick moves to the result register when that is free or drains
   assign slot_move  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue_ok   = !pend_ff || slot_move;
   assign phase_next = (pos_ff == '0) ? PWM_BITS'(phase_ff + 1'b1) : phase_ff;

   // Next state and command execution
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      blank_in   = blank_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      pop        = 1'b0;
      fwr_en     = 1'b0;
      frd_en     = 1'b0;
      frd_addr   = cnt_ff[ADDR_W-1:0];
      bwr_en     = 1'b0;
      bwr_addr   = ADDR_W'(cnt_ff - 1'b1);
      bwr_data   = fv_rd_ff ? frd_data : '0;
      brd_en     = 1'b0;
      tick_issue = 1'b0;
      case (state_ff)
         BK_RUN: begin
            if (head_valid) begin
               case (head_cmd.kind)
                  CMD_DRAW: begin
                     pop    = 1'b1;
                     fwr_en = 1'b1;
                  end
                  CMD_SHOW: begin
                     pop      = 1'b1;
                     state_in = BK_COPY;
                     cnt_in   = '0;
                  end
                  CMD_TICK: begin
                     if (blank_ff) begin
                        pop = 1'b1;
                     end else if (issue_ok) begin
                        pop        = 1'b1;
                        tick_issue = 1'b1;
                        brd_en     = 1'b1;
                        phase_in   = phase_next;
                        pos_in     = ADDR_W'(pos_ff + 1'b1);
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         BK_COPY: begin
            // Read front at cnt, write back at cnt - 1
            frd_en = !cnt_ff[ADDR_W];
            bwr_en = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[ADDR_W]) begin
               state_in = BK_RUN;
               blank_in = 1'b0;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // Result slot control
   always_comb begin
      pend_in = pend_ff;
      if (tick_issue) begin
         pend_in = 1'b1;
      end else if (slot_move) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (slot_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         cnt_ff       <= '0;
         blank_ff     <= 1'b1;
         phase_ff     <= '0;
         pos_ff       <= '0;
         fvalid_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         blank_ff     <= blank_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fwr_en) begin
            fvalid_ff[head_cmd.addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (frd_en) begin
         fv_rd_ff <= fvalid_ff[frd_addr];
      end
      if (tick_issue) begin
         pend_phase_ff <= phase_next;
         pend_latch_ff <= (pos_ff == ADDR_W'(CHAIN_LEN - 1));
      end
      if (slot_move) begin
         rsp_bit_ff   <= (brd_data > LEVEL_W'(pend_phase_ff));
         rsp_latch_ff <= pend_latch_ff;
         rsp_phase_ff <= PHASE_OUT_W'(pend_phase_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bit   = rsp_bit_ff;
   assign rsp_latch = rsp_latch_ff;
   assign rsp_phase = rsp_phase_ff;

   assign status.copy_busy  = (state_ff == BK_COPY);
   assign status.blank      = blank_ff;
   assign status.tick_issue = tick_issue;

endmodule

// ===== sv/led_matrix_pwm_scan_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pwm_scan_driver: serial PWM scan driver for a 16x16 LED matrix
// Front decoder, four-entry command queue and back end with front and back
// frame buffers in RAM.
// ----------------------------------------------------------------------------
// Draws and shift ticks stream through the back end at one per cycle when no
// show copy runs and the result register can take each tick; a tick's serial
// bit goes through the registered read of the back-buffer RAM, beside the
// pending-tick register, and then into the result register. A show holds the
// back end while the front buffer is copied through its single read port one
// entry per cycle; the four-entry queue keeps accepting items meanwhile until
// it fills. The front buffer reads as zero until an entry is drawn, so no
// clearing pass follows reset. Ticks before the first show are dropped with
// no result.
module led_matrix_pwm_scan_driver import lmd_pkg::*; #(
   parameter int PWM_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_coord [15:0], y_coord [31:16], grey_level [47:32]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_bit [0], pwm_phase [6:1], zero [7]
   output logic        rsp_tlast    // latch
);

   cmd_type         front_cmd;
   logic            keep;
   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_valid;
   cmd_type         q_head;
   logic            rsp_bit;
   logic [PHASE_OUT_W-1:0] rsp_phase;
   back_status_type status;

   lmd_front #(.PWM_BITS(PWM_BITS)) u_front (
      .opcode     (req_tuser),
      .x_coord    (req_tdata[15:0]),
      .y_coord    (req_tdata[31:16]),
      .grey_level (req_tdata[47:32]),
      .cmd        (front_cmd),
      .keep       (keep)
   );

   // Accept whenever the queue has room; dropped items are not pushed
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && keep;

   lmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   lmd_back #(.PWM_BITS(PWM_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_cmd   (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_bit    (rsp_bit),
      .rsp_latch  (rsp_tlast),
      .rsp_phase  (rsp_phase),
      .status     (status)
   );

   assign rsp_tdata = {1'b0, rsp_phase, rsp_bit};

   // Never pop an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // No tick is scanned while the buffer copy runs
   a_no_tick_in_copy: assert property (@(posedge clock) disable iff (reset)
      status.copy_busy |-> !status.tick_issue)
      else $error("tick issued during buffer copy");

   // The display is unblanked once a copy finishes
   a_unblank_after_copy: assert property (@(posedge clock) disable iff (reset)
      $fell(status.copy_busy) |-> !status.blank)
      else $error("display still blank after show");

   // A tick is only scanned while the display is lit
   a_tick_needs_lit: assert property (@(posedge clock) disable iff (reset)
      status.tick_issue |-> !status.blank)
      else $error("tick scanned while blank");

endmodule

// ===== bench/tb_led_matrix_pwm_scan_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_pwm_scan_driver: self-checking bench for the LED scan driver
// Streams draw, show, shift-tick and unused-opcode items into the block with random gaps and
// output back-pressure. It keeps its own copy of the frame buffers, gamma
// curve, PWM phase and chain position, and checks every serial bit item
// (data bit, latch mark, phase) against the predicted one in order.
// ----------------------------------------------------------------------------
module tb_led_matrix_pwm_scan_driver;
   import lmd_pkg::*;

   localparam int          PWM_BITS    = 6;
   localparam int          STALL_LIMIT = 5000;
   localparam int          DRAIN_WAIT  = 16;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   typedef struct {
      logic [1:0]         opcode;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        grey;
   } scan_cmd_type;

   typedef struct {
      logic       data_bit;
      logic       latch;
      logic [5:0] phase;
   } scan_bit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // x_coord [15:0], y_coord [31:16], grey_level [47:32]
   logic [1:0]  req_tuser = '0;   // opcode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // data_bit [0], pwm_phase [6:1], zero [7]
   logic        rsp_tlast;        // latch

   // Stimulus and expectation stores
   scan_cmd_type cmd_backlog[$];
   scan_bit_type serial_bits_due[$];
   scan_cmd_type on_bus;
   bit           steady = 1'b0;
   int unsigned  mismatches = 0;

   // Predicted block state
   logic [7:0]          gamma_lut   [CHAIN_LEN];
   logic [7:0]          front_frame [CHAIN_LEN];
   logic [7:0]          back_frame  [CHAIN_LEN];
   logic                blank;
   logic [PWM_BITS-1:0] phase;
   logic [7:0]          scan_pos;

   led_matrix_pwm_scan_driver #(.PWM_BITS(PWM_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Exact gamma curve: largest k with k^10 * 256^27 <= full^10 * i^27, plus one
   function automatic void build_gamma_lut();
      logic [299:0] rhs;
      logic [299:0] lhs;
      int unsigned  full;
      int unsigned  k;
      bit           grow;
      full         = (1 << PWM_BITS) - 1;
      k            = 0;
      gamma_lut[0] = 8'd0;
      for (int i = 1; i < CHAIN_LEN; i++) begin
         rhs = 300'd1;
         repeat (10) rhs = rhs * 300'(full);
         repeat (27) rhs = rhs * 300'(i);
         grow = 1'b1;
         while (grow && k < full) begin
            lhs = 300'd1;
            repeat (10) lhs = lhs * 300'(k + 1);
            lhs = lhs << 216;
            if (lhs <= rhs) k++;
            else grow = 1'b0;
         end
         gamma_lut[i] = 8'(k + 1);
      end
   endfunction

   // Serpentine order of the four 64-LED boards along the shift chain
   function automatic logic [7:0] chain_slot(input logic [3:0] col, input logic [3:0] row);
      logic [7:0] px;
      logic [2:0] c;
      logic [5:0] off;
      px = {row, col};
      c  = px[2:0];
      case (px[5:3])
         3'd0:    off = 6'(c);
         3'd1:    off = 6'(16 + c);
         3'd2:    off = 6'(15 - c);
         3'd3:    off = 6'(31 - c);
         3'd4:    off = 6'(48 + c);
         3'd5:    off = 6'(32 + c);
         3'd6:    off = 6'(63 - c);
         default: off = 6'(47 - c);
      endcase
      return {px[7:6], off};
   endfunction

   // Advance the predicted state by one accepted item
   task automatic apply_command(input scan_cmd_type cmd);
      logic [7:0]   level;
      scan_bit_type due;
      case (cmd.opcode)
         OP_DRAW: begin
            level = (cmd.grey > 16'd255) ? 8'd255 : cmd.grey[7:0];
            if (cmd.x >= 0 && cmd.x <= 15 && cmd.y >= 0 && cmd.y <= 15) begin
               front_frame[chain_slot(4'd15 - cmd.x[3:0], cmd.y[3:0])] = gamma_lut[level];
            end
         end
         OP_SHOW: begin
            back_frame = front_frame;
            blank      = 1'b0;
         end
         OP_TICK: begin
            if (!blank) begin
               // new frame: step the phase first
               if (scan_pos == 8'd0) phase = phase + 1'b1;
               due.data_bit = (back_frame[scan_pos] > 8'(phase));
               due.latch    = (scan_pos == 8'd255);
               due.phase    = 6'(phase);
               serial_bits_due.push_back(due);
               scan_pos = scan_pos + 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_cmd(input logic [1:0] op, input int x, input int y, input int grey);
      scan_cmd_type cmd;
      cmd.opcode = op;
      cmd.x      = 16'(x);
      cmd.y      = 16'(y);
      cmd.grey   = 16'(grey);
      cmd_backlog.push_back(cmd);
   endtask

   // Mostly on-panel draws and ticks, with some off-panel draws, shows and noise
   function automatic scan_cmd_type random_command();
      scan_cmd_type cmd;
      int unsigned  pick;
      pick       = $urandom_range(99);
      cmd.x      = 16'($urandom);
      cmd.y      = 16'($urandom);
      cmd.grey   = 16'($urandom);
      if (pick < 44) begin
         cmd.opcode = OP_DRAW;
         cmd.x      = 16'($urandom_range(15));
         cmd.y      = 16'($urandom_range(15));
         if ($urandom_range(3) != 0) cmd.grey = 16'($urandom_range(255));
      end else if (pick < 50) begin
         cmd.opcode = OP_DRAW;
      end else if (pick < 53) begin
         cmd.opcode = OP_SHOW;
      end else if (pick < 98) begin
         cmd.opcode = OP_TICK;
      end else begin
         cmd.opcode = OP_UNUSED;
      end
      return cmd;
   endfunction

   // Hold until every item went in and every serial bit came back
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_tvalid || serial_bits_due.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: present the next backlog item when the bus slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_command(on_bus);
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
               on_bus = cmd_backlog.pop_front();
               req_tdata  <= {on_bus.grey, on_bus.y, on_bus.x};
               req_tuser  <= on_bus.opcode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each serial bit item with the oldest prediction
   always @(posedge clock) begin
      scan_bit_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (serial_bits_due.size() == 0) begin
               $error("unexpected item: data_bit %0d latch %0d pwm_phase %0d",
                      rsp_tdata[0], rsp_tlast, rsp_tdata[6:1]);
               mismatches++;
            end else begin
               want = serial_bits_due.pop_front();
               if (rsp_tdata[0] !== want.data_bit) begin
                  $error("data_bit: expected %0d, actual %0d", want.data_bit, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tlast !== want.latch) begin
                  $error("latch: expected %0d, actual %0d", want.latch, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tdata[6:1] !== want.phase) begin
                  $error("pwm_phase: expected %0d, actual %0d", want.phase, rsp_tdata[6:1]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 34);
      end
   end

   // Watchdog: stop when no item moves on either side for too long
   always @(posedge clock) begin
      int unsigned quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("led_matrix_pwm_scan_driver: mismatch");
            $finish;
         end
      end
   end

   initial begin
      build_gamma_lut();
      for (int i = 0; i < CHAIN_LEN; i++) begin
         front_frame[i] = 8'd0;
         back_frame[i]  = 8'd0;
      end
      blank    = 1'b1;
      phase    = '0;
      scan_pos = 8'd0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: blank tick, corner and clamp draws, off-panel drops, unused code
      queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_DRAW, 0, 0, 65535);
      queue_cmd(OP_DRAW, 15, 15, 255);
      queue_cmd(OP_DRAW, 15, 0, 256);
      queue_cmd(OP_DRAW, 0, 15, 1);
      queue_cmd(OP_DRAW, 7, 8, 0);
      queue_cmd(OP_DRAW, -1, 3, 100);
      queue_cmd(OP_DRAW, 16, 3, 100);
      queue_cmd(OP_DRAW, 3, -32768, 200);
      queue_cmd(OP_DRAW, 32767, 32767, 300);
      queue_cmd(OP_DRAW, 5, 16, 40);
      queue_cmd(OP_UNUSED, -1, -1, 65535);
      queue_cmd(OP_SHOW, 0, 0, 0);
      repeat (5) queue_cmd(OP_TICK, 0, 0, 0);
      // show in mid-frame takes effect on the remaining bits
      queue_cmd(OP_DRAW, 1, 1, 255);
      queue_cmd(OP_SHOW, 0, 0, 0);
      repeat (3) queue_cmd(OP_TICK, 0, 0, 0);

      // Pause the sender until every serial bit has come back
      wait_drained();

      // Random mix with idling on both sides
      repeat (450) cmd_backlog.push_back(random_command());
      wait_drained();

      // No idling: show the current frame and stream ticks back to back
      steady = 1'b1;
      queue_cmd(OP_SHOW, 0, 0, 0);
      repeat (120) queue_cmd(OP_TICK, 0, 0, 0);
      wait_drained();
      steady = 1'b0;

      repeat (500) cmd_backlog.push_back(random_command());
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (serial_bits_due.size() != 0) begin
         $error("%0d serial bit items never arrived", serial_bits_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("led_matrix_pwm_scan_driver: match");
      end else begin
         $display("led_matrix_pwm_scan_driver: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lmd_pkg.sv
sv/lmd_ram.sv
sv/lmd_front.sv
sv/lmd_queue.sv
sv/lmd_back.sv
sv/led_matrix_pwm_scan_driver.sv
bench/tb_led_matrix_pwm_scan_driver.sv
